### design/sfrc_pkg.sv
// ----------------------------------------------------------------------------
// sfrc_pkg
// shared types, constants and the crc-16 byte step for the frame receiver
// ----------------------------------------------------------------------------
package sfrc_pkg;

  // payload store geometry: two banks of one byte per data position
  localparam int unsigned STORE_DEPTH = 512;

  // data bytes kept per frame
  localparam logic [7:0] MAX_PAYLOAD = 8'd255;

  // crc-16, reflected form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] SLAVE_ADDR_RST = 8'd1;

  typedef enum logic [1:0] {
    ACT_RX      = 2'd0,
    ACT_READ    = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_OTHER    = 2'd2,
    ST_BAD_CRC  = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    PH_ADDR  = 6'b000001,
    PH_FUNC  = 6'b000010,
    PH_LEN   = 6'b000100,
    PH_DATA  = 6'b001000,
    PH_CRCLO = 6'b010000,
    PH_CRCHI = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0] frame_status;
    logic       packet_valid;
    logic [7:0] held_function;
    logic [7:0] held_length;
    logic [7:0] read_data;
  } out_word_t;

  // one byte through the crc, lsb first
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### design/sfrc_ram.sv
// ----------------------------------------------------------------------------
// sfrc_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sfrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/serial_frame_receiver_crc_check.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc_check
// length-framed serial receiver with address match and crc-16 check
// ----------------------------------------------------------------------------
// Takes one word per clock: a received serial byte, a read of the held
// payload, or a release of the held packet. Frames are cut purely by count
// (address, function, length, data bytes, crc low, crc high); the crc-16
// (start 0xFFFF, reflected poly 0xA001) covers the length and data bytes only.
// Every input word gives exactly one result word, through the store-read stage
// and then the output register. Unstalled, the rate is one word per cycle:
// all frame state updates in the cycle a word is taken, and the only extra
// stage is the registered read of the payload store. in_ready_o drops only
// when both the store-read stage and the output register are full and the
// output is stalled. The payload store is a 512 x 8 ram in two banks; data
// bytes fill one bank while the other holds the last accepted packet, and
// acceptance flips the banks. The slave address register may be written only
// while the block is idle.
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc_check (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sfrc_pkg::in_word_t   in_word_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sfrc_pkg::out_word_t  out_word_o
);

  // frame state
  sfrc_pkg::phase_e phase_q, phase_d;
  logic [7:0]       slave_addr_q;
  logic [7:0]       frm_addr_q, frm_addr_d;
  logic [7:0]       frm_func_q, frm_func_d;
  logic [7:0]       frm_len_q, frm_len_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       crc_lo_q, crc_lo_d;
  logic             bank_q, bank_d;
  // held packet
  logic [7:0]       held_func_q, held_func_d;
  logic [7:0]       held_len_q, held_len_d;
  logic             held_valid_q, held_valid_d;

  // store-read stage and output register
  logic                p1_valid_q;
  logic                p1_rd_q;
  sfrc_pkg::out_word_t p1_word_q, p1_word_d;
  logic                o_valid_q;
  sfrc_pkg::out_word_t o_word_q, o_word_d;

  logic       accept;
  logic       p1_adv;
  logic       ram_we, ram_re;
  logic [7:0] cnt_inc;
  logic [15:0] crc_got;
  logic [7:0] ram_rdata;
  logic [1:0] status;

  // handshake: output register frees, then the read stage moves into it
  assign p1_adv     = p1_valid_q && (!o_valid_q || out_ready_i);
  assign in_ready_o = !p1_valid_q || p1_adv;
  assign accept     = in_valid_i && in_ready_o;

  assign cnt_inc = cnt_q + 8'd1;
  assign crc_got = {in_word_i.rx_byte, crc_lo_q};

  // frame sequencing, all updates land on the accepting edge
  always_comb begin
    phase_d      = phase_q;
    frm_addr_d   = frm_addr_q;
    frm_func_d   = frm_func_q;
    frm_len_d    = frm_len_q;
    cnt_d        = cnt_q;
    crc_d        = crc_q;
    crc_lo_d     = crc_lo_q;
    bank_d       = bank_q;
    held_func_d  = held_func_q;
    held_len_d   = held_len_q;
    held_valid_d = held_valid_q;
    status       = sfrc_pkg::ST_PENDING;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    if (accept) begin
      case (in_word_i.action)
        sfrc_pkg::ACT_RX: begin
          case (phase_q)
            sfrc_pkg::PH_ADDR: begin
              frm_addr_d = in_word_i.rx_byte;
              phase_d    = sfrc_pkg::PH_FUNC;
            end
            sfrc_pkg::PH_FUNC: begin
              frm_func_d = in_word_i.rx_byte;
              phase_d    = sfrc_pkg::PH_LEN;
            end
            sfrc_pkg::PH_LEN: begin
              frm_len_d = in_word_i.rx_byte;
              cnt_d     = 8'd0;
              crc_d     = sfrc_pkg::crc_step(sfrc_pkg::CRC_INIT, in_word_i.rx_byte);
              // zero length goes straight to the crc bytes
              phase_d   = (in_word_i.rx_byte == 8'd0) ? sfrc_pkg::PH_CRCLO
                                                      : sfrc_pkg::PH_DATA;
            end
            sfrc_pkg::PH_DATA: begin
              crc_d  = sfrc_pkg::crc_step(crc_q, in_word_i.rx_byte);
              // bytes past the store size still enter the crc
              ram_we = (cnt_q < sfrc_pkg::MAX_PAYLOAD);
              cnt_d  = cnt_inc;
              if (cnt_inc == frm_len_q) begin
                phase_d = sfrc_pkg::PH_CRCLO;
              end
            end
            sfrc_pkg::PH_CRCLO: begin
              crc_lo_d = in_word_i.rx_byte;
              phase_d  = sfrc_pkg::PH_CRCHI;
            end
            sfrc_pkg::PH_CRCHI: begin
              // address is judged ahead of the crc
              if (frm_addr_q != slave_addr_q) begin
                status = sfrc_pkg::ST_OTHER;
              end else if (crc_got != crc_q) begin
                status = sfrc_pkg::ST_BAD_CRC;
              end else begin
                status       = sfrc_pkg::ST_ACCEPTED;
                held_func_d  = frm_func_q;
                held_len_d   = (frm_len_q > sfrc_pkg::MAX_PAYLOAD) ? sfrc_pkg::MAX_PAYLOAD
                                                                   : frm_len_q;
                held_valid_d = 1'b1;
                bank_d       = ~bank_q;
              end
              phase_d = sfrc_pkg::PH_ADDR;
            end
            default: begin
              phase_d = sfrc_pkg::PH_ADDR;
            end
          endcase
        end
        sfrc_pkg::ACT_READ: begin
          // out-of-range or no packet reads as zero, store is not touched
          ram_re = held_valid_q && (in_word_i.read_index < held_len_q);
        end
        sfrc_pkg::ACT_RELEASE: begin
          held_valid_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // result fields that are known on the accepting edge
  always_comb begin
    p1_word_d               = '0;
    p1_word_d.frame_status  = status;
    p1_word_d.packet_valid  = held_valid_d;
    p1_word_d.held_function = held_valid_d ? held_func_d : 8'd0;
    p1_word_d.held_length   = held_valid_d ? held_len_d : 8'd0;
  end

  // the held bank is the one not being filled
  sfrc_ram #(
    .WIDTH (8),
    .DEPTH (sfrc_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({bank_q, cnt_q}),
    .wdata_i (in_word_i.rx_byte),
    .re_i    (ram_re),
    .raddr_i ({~bank_q, in_word_i.read_index}),
    .rdata_o (ram_rdata)
  );

  // read data joins the word as it moves into the output register
  always_comb begin
    o_word_d           = p1_word_q;
    o_word_d.read_data = p1_rd_q ? ram_rdata : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= sfrc_pkg::PH_ADDR;
      slave_addr_q <= sfrc_pkg::SLAVE_ADDR_RST;
      frm_addr_q   <= 8'd0;
      frm_func_q   <= 8'd0;
      frm_len_q    <= 8'd0;
      cnt_q        <= 8'd0;
      crc_q        <= sfrc_pkg::CRC_INIT;
      crc_lo_q     <= 8'd0;
      bank_q       <= 1'b0;
      held_func_q  <= 8'd0;
      held_len_q   <= 8'd0;
      held_valid_q <= 1'b0;
      p1_valid_q   <= 1'b0;
      o_valid_q    <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      frm_addr_q   <= frm_addr_d;
      frm_func_q   <= frm_func_d;
      frm_len_q    <= frm_len_d;
      cnt_q        <= cnt_d;
      crc_q        <= crc_d;
      crc_lo_q     <= crc_lo_d;
      bank_q       <= bank_d;
      held_func_q  <= held_func_d;
      held_len_q   <= held_len_d;
      held_valid_q <= held_valid_d;
      if (cfg_we_i) begin
        slave_addr_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        p1_valid_q <= in_valid_i;
      end
      if (p1_adv) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_word_q <= p1_word_d;
      p1_rd_q   <= ram_re;
    end
    if (p1_adv) begin
      o_word_q <= o_word_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_word_o  = o_word_q;

endmodule

### design/sfrc_checker.sv
// ----------------------------------------------------------------------------
// sfrc_checker
// port-level checks on the frame receiver, bound to the top level
// ----------------------------------------------------------------------------
module sfrc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic [7:0]          cfg_wdata_i,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input sfrc_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input sfrc_pkg::out_word_t out_word_o
);

  // stalled result word holds
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // no held packet means zero held fields
  a_held_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.packet_valid |->
      out_word_o.held_function == 8'd0 && out_word_o.held_length == 8'd0)
    else $error("held fields nonzero without packet");

  // an accepted frame leaves a packet held
  a_accept_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.frame_status == sfrc_pkg::ST_ACCEPTED |->
      out_word_o.packet_valid)
    else $error("accepted frame without held packet");

  // read data only comes from a held packet
  a_read_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.read_data != 8'd0 |->
      out_word_o.packet_valid && out_word_o.frame_status == sfrc_pkg::ST_PENDING)
    else $error("read data without held packet");

endmodule

bind serial_frame_receiver_crc_check sfrc_checker u_sfrc_checker (.*);

### sim/serial_frame_receiver_crc_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc_check_tb
// self-checking bench for the length-framed receiver with crc-16 check
// ----------------------------------------------------------------------------
// Sends serial byte words, payload reads and releases through the valid/ready
// input channel. A scoreboard class mirrors the framing, crc, two-bank payload
// store and held packet, and checks every result word in order. The slave
// address is changed between phases, extremes included, while the block is
// idle. Random traffic is mostly well-formed frames, with other-address and
// bad-crc frames, cut frames and stray bytes mixed in.
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc_check_tb;

  localparam int CLK_HALF     = 5;
  localparam int TIMEOUT_NS   = 4_000_000;
  localparam int PHASE_WORDS  = 340;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTS   = 40;
  localparam logic [7:0] ADDR_PLAN [5] = '{8'd247, 8'd0, 8'd255, 8'd0, 8'd1};

  // scoreboard: tracks frame state and queues the expected result words
  class frame_scoreboard;
    logic [7:0]          slave_addr;
    sfrc_pkg::phase_e    phase;
    logic [7:0]          frm_addr;
    logic [7:0]          frm_func;
    logic [7:0]          frm_len;
    logic [7:0]          data_count;
    logic [7:0]          crc_lo;
    logic [15:0]         crc_acc;
    logic [7:0]          payload [sfrc_pkg::STORE_DEPTH];
    logic                fill_bank;
    logic [7:0]          held_func;
    logic [7:0]          held_len;
    logic                held_valid;
    sfrc_pkg::out_word_t expected_words [$];
    int                  mismatch_count;

    function new();
      slave_addr     = sfrc_pkg::SLAVE_ADDR_RST;
      phase          = sfrc_pkg::PH_ADDR;
      frm_addr       = '0;
      frm_func       = '0;
      frm_len        = '0;
      data_count     = '0;
      crc_lo         = '0;
      crc_acc        = sfrc_pkg::CRC_INIT;
      fill_bank      = 1'b0;
      held_func      = '0;
      held_len       = '0;
      held_valid     = 1'b0;
      mismatch_count = 0;
    endfunction

    static function logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ sfrc_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void note_accepted_word(sfrc_pkg::in_word_t w);
      sfrc_pkg::out_word_t want;
      sfrc_pkg::status_e   status;
      want   = '0;
      status = sfrc_pkg::ST_PENDING;
      case (w.action)
        sfrc_pkg::ACT_RX: begin
          case (phase)
            sfrc_pkg::PH_ADDR: begin
              frm_addr = w.rx_byte;
              phase    = sfrc_pkg::PH_FUNC;
            end
            sfrc_pkg::PH_FUNC: begin
              frm_func = w.rx_byte;
              phase    = sfrc_pkg::PH_LEN;
            end
            sfrc_pkg::PH_LEN: begin
              // crc restarts on the length byte
              frm_len    = w.rx_byte;
              data_count = '0;
              crc_acc    = crc16_byte(sfrc_pkg::CRC_INIT, w.rx_byte);
              phase      = (w.rx_byte == 8'd0) ? sfrc_pkg::PH_CRCLO : sfrc_pkg::PH_DATA;
            end
            sfrc_pkg::PH_DATA: begin
              crc_acc = crc16_byte(crc_acc, w.rx_byte);
              if (data_count < sfrc_pkg::MAX_PAYLOAD) begin
                payload[{fill_bank, data_count}] = w.rx_byte;
              end
              data_count = data_count + 8'd1;
              if (data_count == frm_len) begin
                phase = sfrc_pkg::PH_CRCLO;
              end
            end
            sfrc_pkg::PH_CRCLO: begin
              crc_lo = w.rx_byte;
              phase  = sfrc_pkg::PH_CRCHI;
            end
            default: begin
              // address is judged before the crc
              if (frm_addr != slave_addr) begin
                status = sfrc_pkg::ST_OTHER;
              end else if ({w.rx_byte, crc_lo} != crc_acc) begin
                status = sfrc_pkg::ST_BAD_CRC;
              end else begin
                status     = sfrc_pkg::ST_ACCEPTED;
                held_func  = frm_func;
                held_len   = (frm_len > sfrc_pkg::MAX_PAYLOAD) ? sfrc_pkg::MAX_PAYLOAD
                                                               : frm_len;
                held_valid = 1'b1;
                fill_bank  = ~fill_bank;
              end
              phase = sfrc_pkg::PH_ADDR;
            end
          endcase
        end
        sfrc_pkg::ACT_READ: begin
          if (held_valid && w.read_index < held_len) begin
            want.read_data = payload[{~fill_bank, w.read_index}];
          end
        end
        sfrc_pkg::ACT_RELEASE: begin
          held_valid = 1'b0;
        end
        default: ;
      endcase
      want.frame_status  = status;
      want.packet_valid  = held_valid;
      want.held_function = held_valid ? held_func : 8'd0;
      want.held_length   = held_valid ? held_len : 8'd0;
      expected_words.push_back(want);
    endfunction

    task report_mismatch(string what, int got_v, int want_v);
      if (mismatch_count < MAX_PRINTS) begin
        $display("%0t ns: mismatch on %s, got 0x%0h, want 0x%0h", $time, what, got_v, want_v);
      end
      mismatch_count++;
    endtask

    task check_result_word(sfrc_pkg::out_word_t got);
      sfrc_pkg::out_word_t want;
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing expected", got, 0);
        return;
      end
      want = expected_words.pop_front();
      if (got.frame_status !== want.frame_status) begin
        report_mismatch("frame_status", got.frame_status, want.frame_status);
      end
      if (got.packet_valid !== want.packet_valid) begin
        report_mismatch("packet_valid", got.packet_valid, want.packet_valid);
      end
      if (got.held_function !== want.held_function) begin
        report_mismatch("held_function", got.held_function, want.held_function);
      end
      if (got.held_length !== want.held_length) begin
        report_mismatch("held_length", got.held_length, want.held_length);
      end
      if (got.read_data !== want.read_data) begin
        report_mismatch("read_data", got.read_data, want.read_data);
      end
    endtask
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [7:0]          cfg_wdata_i = 8'd0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  sfrc_pkg::in_word_t  in_word_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  sfrc_pkg::out_word_t out_word_o;

  frame_scoreboard sb = new();

  // idling controls shared by the sender and the receiver
  bit src_gaps  = 1'b1;
  bit sink_gaps = 1'b1;
  bit hold_req  = 1'b0;
  int hold_left = 0;
  int words_sent;
  int big_frames = 0;

  serial_frame_receiver_crc_check dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // random byte with the extremes weighted in
  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(7);
    if (r == 0) begin
      return 8'h00;
    end
    if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom_range(255));
  endfunction

  // mostly short frames, a few mid-size ones, at most a handful at full size
  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r == 0 && big_frames < 3) begin
      big_frames++;
      return 8'd255;
    end
    if (r < 75) begin
      return 8'($urandom_range(6));
    end
    return 8'($urandom_range(7, 40));
  endfunction

  // offer one word and hold it until it is taken; idle gap before it at random
  task automatic send_word(input logic [1:0] act, input logic [7:0] rx, input logic [7:0] ridx);
    sfrc_pkg::in_word_t w;
    w.action     = act;
    w.rx_byte    = rx;
    w.read_index = ridx;
    if (src_gaps && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_accepted_word(w);
    if (act != sfrc_pkg::ACT_NONE) begin
      words_sent++;
    end
  endtask

  // build a frame; keep > 0 cuts it after that many bytes
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] len,
                            input bit bad_crc, input int keep);
    logic [7:0]  seq [$];
    logic [15:0] crc;
    logic [7:0]  d;
    seq.push_back(addr);
    seq.push_back(rand_byte());
    seq.push_back(len);
    crc = frame_scoreboard::crc16_byte(sfrc_pkg::CRC_INIT, len);
    for (int i = 0; i < int'(len); i++) begin
      d = rand_byte();
      seq.push_back(d);
      crc = frame_scoreboard::crc16_byte(crc, d);
    end
    if (bad_crc) begin
      crc = crc ^ (16'h0001 << $urandom_range(15));
    end
    seq.push_back(crc[7:0]);
    seq.push_back(crc[15:8]);
    if (keep > 0) begin
      while (seq.size() > keep) void'(seq.pop_back());
    end
    foreach (seq[i]) send_word(sfrc_pkg::ACT_RX, seq[i], rand_byte());
  endtask

  // walk the framing back to the address byte, short length if one is due
  task automatic resync_framing();
    while (sb.phase != sfrc_pkg::PH_ADDR) begin
      send_word(sfrc_pkg::ACT_RX,
                (sb.phase == sfrc_pkg::PH_LEN) ? 8'($urandom_range(3)) : rand_byte(),
                rand_byte());
    end
  endtask

  task automatic read_held();
    logic [7:0] idx;
    if (sb.held_valid && sb.held_len != 0 && $urandom_range(3) != 0) begin
      idx = 8'($urandom_range(sb.held_len - 1));
    end else begin
      idx = rand_byte();
    end
    send_word(sfrc_pkg::ACT_READ, rand_byte(), idx);
  endtask

  // sender stops and waits until every result word is back
  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_address(input logic [7:0] a);
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    sb.slave_addr = a;
  endtask

  // receiver: checks taken result words, stalls at random or for a long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result_word(out_word_o);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !sink_gaps || ($urandom_range(99) >= 18);
      end
    end
  end

  // stimulus
  initial begin
    int         r;
    logic [7:0] addr;
    bit         hold_done;
    bit         pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty reads and release, zero length, short frame, bad crc,
    // other address, release of a held packet
    set_address(8'd1);
    send_word(sfrc_pkg::ACT_READ, rand_byte(), 8'd0);
    send_word(sfrc_pkg::ACT_RELEASE, rand_byte(), rand_byte());
    send_word(sfrc_pkg::ACT_NONE, 8'hFF, 8'hFF);
    send_frame(8'd1, 8'd0, 1'b0, 0);
    send_word(sfrc_pkg::ACT_READ, 8'h00, 8'd0);
    send_frame(8'd1, 8'd2, 1'b0, 0);
    send_word(sfrc_pkg::ACT_READ, 8'hFF, 8'd0);
    send_word(sfrc_pkg::ACT_READ, 8'h00, 8'd1);
    send_word(sfrc_pkg::ACT_READ, 8'hFF, 8'd255);
    send_frame(8'd1, 8'd1, 1'b1, 0);
    send_frame(8'd247, 8'd0, 1'b0, 0);
    send_word(sfrc_pkg::ACT_RELEASE, 8'h00, 8'h00);
    send_word(sfrc_pkg::ACT_READ, 8'h00, 8'd0);

    // random phases, one slave address each
    for (int p = 0; p < 5; p++) begin
      addr      = (p == 3) ? 8'($urandom_range(2, 246)) : ADDR_PLAN[p];
      // one whole phase runs with no idling on either side
      src_gaps  = (p != 1);
      sink_gaps = (p != 1);
      set_address(addr);
      words_sent = 0;
      while (words_sent < PHASE_WORDS) begin
        // long receiver hold-off while the sender keeps going
        if (p == 2 && !hold_done && words_sent > 100) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        if (p == 3 && !pause_done && words_sent > 150) begin
          wait_results();
          pause_done = 1'b1;
        end
        r = $urandom_range(99);
        if (r < 55) begin
          send_frame(sb.slave_addr, pick_len(), 1'b0, 0);
        end else if (r < 62) begin
          send_frame(sb.slave_addr ^ 8'($urandom_range(1, 255)), pick_len(), 1'b0, 0);
        end else if (r < 70) begin
          send_frame(sb.slave_addr, pick_len(), 1'b1, 0);
        end else if (r < 82) begin
          repeat ($urandom_range(1, 4)) read_held();
        end else if (r < 86) begin
          send_word(sfrc_pkg::ACT_RELEASE, rand_byte(), rand_byte());
        end else if (r < 89) begin
          send_word(sfrc_pkg::ACT_NONE, rand_byte(), rand_byte());
        end else if (r < 94) begin
          // frame cut short, next bytes land mid-frame
          send_frame(sb.slave_addr, 8'($urandom_range(6)), 1'b0, $urandom_range(1, 6));
          resync_framing();
        end else begin
          repeat ($urandom_range(1, 3)) send_word(sfrc_pkg::ACT_RX, rand_byte(), rand_byte());
          resync_framing();
        end
      end
    end

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
design/sfrc_pkg.sv
design/sfrc_ram.sv
design/serial_frame_receiver_crc_check.sv
design/sfrc_checker.sv
sim/serial_frame_receiver_crc_check_tb.sv
